[hdl/scgt_pkg.sv]
// Package for the signing conflict guard table.
// Holds entry layout, status and operation codes, controller state and the
// command/status structs shared by controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package scgt_pkg;

	localparam int KIND_W      = 2;
	localparam int HEIGHT_W    = 64;
	localparam int ROUND_W     = 32;
	localparam int HWORD_W     = 64;
	localparam int HASH_W      = 4 * HWORD_W;
	localparam int COUNT_OUT_W = 11;

	localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;
	localparam logic OP_RECORD  = 1'b0;
	localparam logic OP_RESTORE = 1'b1;

	typedef enum logic [2:0] {
		ST_APPENDED = 3'd0,
		ST_REPEAT   = 3'd1,
		ST_CONFLICT = 3'd2,
		ST_INVALID  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	// One stored row; hash word 0 sits in the low bits
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [HEIGHT_W-1:0] height;
		logic [ROUND_W-1:0]  round;
		logic [HASH_W-1:0]   hash;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_APPEND,
		S_RESP
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic    capture;
		logic    scan_start;
		logic    scan;
		logic    append;
		logic    out_load;
		status_t status;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic invalid;
		logic empty;
		logic full;
		logic op;
		logic hit_vld;
		logic hash_hit;
		logic last_vld;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

[hdl/scgt_req_if.sv]
// Request channel of the signing conflict guard table.
// Depends on nothing but the valid/ready handshake it carries.
`timescale 1ns / 1ps
`default_nettype none
interface scgt_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [1:0]  kind;
	logic [63:0] height;
	logic [31:0] round;
	logic [63:0] hash_word0;
	logic [63:0] hash_word1;
	logic [63:0] hash_word2;
	logic [63:0] hash_word3;

	modport source (output valid, operation, kind, height, round,
		hash_word0, hash_word1, hash_word2, hash_word3, input ready);
	modport sink (input valid, operation, kind, height, round,
		hash_word0, hash_word1, hash_word2, hash_word3, output ready);
endinterface
`default_nettype wire

[hdl/scgt_rsp_if.sv]
// Response channel of the signing conflict guard table.
// Uses status_t from scgt_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface scgt_rsp_if;
	logic                  valid;
	logic                  ready;
	scgt_pkg::status_t     status;
	logic [10:0]           entry_count_out;

	modport source (output valid, status, entry_count_out, input ready);
	modport sink (input valid, status, entry_count_out, output ready);
endinterface
`default_nettype wire

[hdl/scgt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; no reset on the array or the read register.
`timescale 1ns / 1ps
`default_nettype none
module scgt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                        clk,
	input  wire logic                                        wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                            wr_data,
	input  wire logic                                        rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                            rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

[hdl/scgt_ctrl.sv]
// Controller of the signing conflict guard table: sequences check, scan,
// append and response. Depends on scgt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scgt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire scgt_pkg::dp_stat_t stat,
	output scgt_pkg::dp_cmd_t       cmd
);
	import scgt_pkg::*;

	ctrl_state_t state_q, state_d;
	status_t     res_q, res_d;

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= ST_APPENDED;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		res_d     = res_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.status = res_q;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (stat.invalid) begin
					res_d   = ST_INVALID;
					state_d = S_RESP;
				end else if (stat.empty) begin
					state_d = S_APPEND;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				// first key match decides a record; a restore only stops on a new hash
				priority if (stat.hit_vld && stat.op == OP_RECORD) begin
					res_d   = stat.hash_hit ? ST_REPEAT : ST_CONFLICT;
					state_d = S_RESP;
				end else if (stat.hit_vld && !stat.hash_hit) begin
					res_d   = ST_CONFLICT;
					state_d = S_RESP;
				end else if (stat.last_vld) begin
					state_d = S_APPEND;
				end
			end
			S_APPEND: begin
				if (stat.full) begin
					res_d = ST_FULL;
				end else begin
					cmd.append = 1'b1;
					res_d      = ST_APPENDED;
				end
				state_d = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Never append into a full table
	a_no_append_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> !stat.full)
		else $error("append issued on full table");

	// A waiting result leaves as soon as the output slot frees
	a_resp_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && stat.out_free) |=> state_q == S_IDLE)
		else $error("response state did not release");
endmodule
`default_nettype wire

[hdl/scgt_dp.sv]
// Datapath of the signing conflict guard table: request registers, entry
// count, scan index, entry RAM, key/hash compare and output register.
// Depends on scgt_pkg and scgt_ram.
`timescale 1ns / 1ps
`default_nettype none
module scgt_dp #(
	parameter int MAX_ENTRIES = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire scgt_pkg::dp_cmd_t              cmd,
	output scgt_pkg::dp_stat_t                  stat,
	input  wire logic                           in_operation,
	input  wire logic [scgt_pkg::KIND_W-1:0]    in_kind,
	input  wire logic [scgt_pkg::HEIGHT_W-1:0]  in_height,
	input  wire logic [scgt_pkg::ROUND_W-1:0]   in_round,
	input  wire logic [scgt_pkg::HWORD_W-1:0]   in_hash_word0,
	input  wire logic [scgt_pkg::HWORD_W-1:0]   in_hash_word1,
	input  wire logic [scgt_pkg::HWORD_W-1:0]   in_hash_word2,
	input  wire logic [scgt_pkg::HWORD_W-1:0]   in_hash_word3,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output scgt_pkg::status_t                   out_status,
	output logic [scgt_pkg::COUNT_OUT_W-1:0]    out_count
);
	import scgt_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic            op_q;
	entry_t          req_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   idx_q;
	logic            issuing_q;
	logic            rd_vld_s1;
	logic            last_s1;
	logic            rd_issue;
	logic            idx_last;
	entry_t          rd_entry;
	logic            key_hit;
	logic [31:0]     count_ext;
	logic            out_vld_q;
	status_t         out_status_q;
	logic [COUNT_OUT_W-1:0] out_count_q;

	// Hold the accepted request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q         <= in_operation;
			req_q.kind   <= in_kind;
			req_q.height <= in_height;
			req_q.round  <= in_round;
			req_q.hash   <= {in_hash_word3, in_hash_word2, in_hash_word1, in_hash_word0};
		end
	end

	// Entry count: advance on append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.append) begin
			count_q <= count_q + CW'(1);
		end
	end

	// Scan index: one read issued per cycle up to the last stored entry
	assign rd_issue = cmd.scan && issuing_q;
	assign idx_last = (CW'(idx_q) + CW'(1)) == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			issuing_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (cmd.scan_start) begin
				idx_q     <= '0;
				issuing_q <= 1'b1;
				last_s1   <= 1'b0;
			end else if (rd_issue) begin
				idx_q     <= idx_q + AW'(1);
				issuing_q <= !idx_last;
				last_s1   <= idx_last;
			end
		end
	end

	scgt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_ENTRIES)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (cmd.append),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (req_q),
		.rd_en   (rd_issue),
		.rd_addr (idx_q),
		.rd_data (rd_entry)
	);

	// Compare the entry read last cycle
	assign key_hit = rd_entry.kind == req_q.kind && rd_entry.height == req_q.height &&
		rd_entry.round == req_q.round;

	always_comb begin
		stat          = '0;
		stat.invalid  = req_q.kind == KIND_INVALID || req_q.hash == '0;
		stat.empty    = count_q == '0;
		stat.full     = count_q == CW'(MAX_ENTRIES);
		stat.op       = op_q;
		stat.hit_vld  = rd_vld_s1 && key_hit;
		stat.hash_hit = rd_entry.hash == req_q.hash;
		stat.last_vld = rd_vld_s1 && last_s1;
		stat.out_free = !out_vld_q || out_ready;
	end

	// Output register
	assign count_ext = 32'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= cmd.status;
			out_count_q  <= count_ext[COUNT_OUT_W-1:0];
		end
	end

	assign out_valid  = out_vld_q;
	assign out_status = out_status_q;
	assign out_count  = out_count_q;

	// Count never runs past the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond table size");

	// Each append adds exactly one entry
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |=> count_q == $past(count_q) + CW'(1))
		else $error("entry count did not advance on append");
endmodule
`default_nettype wire

[hdl/signing_conflict_guard_table.sv]
// Top level of the signing conflict guard table.
// Depends on scgt_pkg, scgt_req_if, scgt_rsp_if, scgt_ctrl, scgt_dp, scgt_ram.
//
//   channel  dir  beat payload
//   req      in   operation, kind, height, round, hash_word0..hash_word3
//   rsp      out  status, entry_count_out
//
// An item runs from accept through check, scan and append, as needed, to
// result load: the scan reads one stored entry per cycle through the
// single read port of the entry RAM. An append into an empty table skips
// the scan, and an invalid request goes from the check straight to the response.
// Reset clears the entry count, not the entry RAM; the RAM needs no clearing pass.
// A stalled rsp holds the finished result in the output register; the next
// request is taken meanwhile and waits before its own result load.
`timescale 1ns / 1ps
`default_nettype none
module signing_conflict_guard_table #(
	parameter int MAX_ENTRIES = 1024
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	scgt_req_if.sink     req,
	scgt_rsp_if.source   rsp
);
	import scgt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     req_ready;

	scgt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	scgt_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_operation  (req.operation),
		.in_kind       (req.kind),
		.in_height     (req.height),
		.in_round      (req.round),
		.in_hash_word0 (req.hash_word0),
		.in_hash_word1 (req.hash_word1),
		.in_hash_word2 (req.hash_word2),
		.in_hash_word3 (req.hash_word3),
		.out_ready     (rsp.ready),
		.out_valid     (rsp.valid),
		.out_status    (rsp.status),
		.out_count     (rsp.entry_count_out)
	);

	assign req.ready = req_ready;
endmodule
`default_nettype wire

[tb/tb_signing_conflict_guard_table.sv]
// Testbench for signing_conflict_guard_table: drives request beats, predicts status and count.
// Depends on scgt_pkg, scgt_req_if, scgt_rsp_if and the top level of the block.
// Covers a directed part and a random part with one long rsp hold-off.
`timescale 1ns / 1ps
import scgt_pkg::*;

localparam int TABLE_DEPTH = 1024;

typedef struct {
	logic             op;
	logic [1:0]       kind;
	logic [63:0]      height;
	logic [31:0]      round;
	logic [3:0][63:0] hash;     // hash[0] is hash_word0
} sign_req_t;

typedef struct {
	status_t     status;
	logic [10:0] count;
} guard_result_t;

// Tracks its own copy of the signing table and the results still owed
class guard_scoreboard;
	logic [1:0]       kind_mem[TABLE_DEPTH];
	logic [63:0]      height_mem[TABLE_DEPTH];
	logic [31:0]      round_mem[TABLE_DEPTH];
	logic [3:0][63:0] hash_mem[TABLE_DEPTH];
	int unsigned      fill;
	guard_result_t    pending[$];
	int unsigned      errors;
	int unsigned      checked;
	int unsigned      status_seen[5];

	// Decide the outcome of one accepted request and update the table
	function void note_request(sign_req_t r);
		status_t     st;
		bit          decided;
		int unsigned i;
		st = ST_APPENDED;
		decided = 1'b0;
		if (r.kind == KIND_INVALID || r.hash == '0) begin
			st = ST_INVALID;
			decided = 1'b1;
		end
		// The first entry with the same key decides a record; a restore
		// stops only at an entry with the same key and another hash
		for (i = 0; i < fill && !decided; i++) begin
			if (kind_mem[i] == r.kind && height_mem[i] == r.height &&
					round_mem[i] == r.round) begin
				if (r.op == OP_RECORD) begin
					st = (hash_mem[i] == r.hash) ? ST_REPEAT : ST_CONFLICT;
					decided = 1'b1;
				end else if (hash_mem[i] != r.hash) begin
					st = ST_CONFLICT;
					decided = 1'b1;
				end
			end
		end
		if (!decided) begin
			if (fill >= TABLE_DEPTH) begin
				st = ST_FULL;
			end else begin
				kind_mem[fill] = r.kind;
				height_mem[fill] = r.height;
				round_mem[fill] = r.round;
				hash_mem[fill] = r.hash;
				fill++;
			end
		end
		pending.push_back('{st, 11'(fill)});
	endfunction

	// Compare one result beat with the oldest prediction
	function void check_result(status_t st, logic [10:0] cnt);
		guard_result_t want;
		if (pending.size() == 0) begin
			$display("%0t: result with nothing pending: status %0d count %0d",
				$time, st, cnt);
			errors++;
			return;
		end
		want = pending.pop_front();
		checked++;
		if (st !== want.status) begin
			$display("%0t: status mismatch: expected %0d actual %0d",
				$time, want.status, st);
			errors++;
		end
		if (cnt !== want.count) begin
			$display("%0t: entry count mismatch: expected %0d actual %0d",
				$time, want.count, cnt);
			errors++;
		end
		if (int'(st) < 5)
			status_seen[int'(st)]++;
	endfunction
endclass

module tb_signing_conflict_guard_table;

	localparam int CYCLE_LIMIT    = 6_000_000;
	localparam int IDLE_PCT       = 36;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int RANDOM_ITEMS   = 560;
	localparam int DRAIN_CYCLES   = TABLE_DEPTH + 16;

	logic clk = 1'b0;
	logic arst_n;

	scgt_req_if req ();
	scgt_rsp_if rsp ();

	signing_conflict_guard_table #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	guard_scoreboard sb;
	sign_req_t       signed_log[$];
	bit              quiet = 1'b0;
	bit              holdoff_req = 1'b0;
	int unsigned     cycles = 0;
	int unsigned     sent = 0;
	int unsigned     input_stalls = 0;

	always #5 clk = ~clk;

	// Count cycles, stalled request beats, and stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && req.valid && !req.ready)
			input_stalls <= input_stalls + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still pending",
				$time, cycles, sb.pending.size());
			$display("** signing_conflict_guard_table: FAILED **");
			$finish;
		end
	end

	// Check every accepted result beat
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result(rsp.status, rsp.entry_count_out);
	end

	// Drive rsp ready: random stalls, a quiet stretch, one long hold-off
	initial begin : rsp_drive
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (holdoff_req && !held) begin
				hold_left = HOLDOFF_CYCLES;
				held = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic sign_req_t build(logic op, logic [1:0] kind, logic [63:0] height,
			logic [31:0] round, logic [63:0] w3, logic [63:0] w2, logic [63:0] w1,
			logic [63:0] w0);
		sign_req_t r;
		r.op = op;
		r.kind = kind;
		r.height = height;
		r.round = round;
		r.hash = {w3, w2, w1, w0};
		return r;
	endfunction

	// Random key, valid kind, nonzero hash; small heights and rounds often collide
	function automatic sign_req_t fresh_request(logic op);
		sign_req_t r;
		r.op = op;
		r.kind = 2'($urandom_range(2));
		r.height = $urandom_range(1) ? rand64() : 64'($urandom_range(15));
		r.round = $urandom_range(1) ? $urandom : 32'($urandom_range(3));
		r.hash = {rand64(), rand64(), rand64(), rand64()};
		if (r.hash == '0)
			r.hash[0] = 64'd1;
		return r;
	endfunction

	// Mostly replays of earlier signings with random twists, some noise
	function automatic sign_req_t random_request();
		sign_req_t   r;
		int unsigned pick;
		int unsigned w;
		pick = $urandom_range(99);
		if (signed_log.size() == 0 || pick < 30)
			return fresh_request(1'($urandom_range(1)));
		r = signed_log[$urandom_range(signed_log.size() - 1)];
		w = $urandom_range(3);
		if (pick < 45) begin
			r.op = OP_RECORD;
		end else if (pick < 55) begin
			r.op = OP_RECORD;
			r.hash[w] = r.hash[w] ^ (64'd1 << $urandom_range(63));
		end else if (pick < 70) begin
			r.op = OP_RESTORE;
		end else if (pick < 76) begin
			r.op = OP_RESTORE;
			r.hash[w] = r.hash[w] ^ (64'd1 << $urandom_range(63));
		end else if (pick < 84) begin
			// Near miss: one key field differs
			r.op = 1'($urandom_range(1));
			case ($urandom_range(2))
				0: r.kind = 2'((int'(r.kind) + 1 + $urandom_range(1)) % 3);
				1: r.height = r.height ^ (64'd1 << $urandom_range(63));
				default: r.round = r.round ^ (32'd1 << $urandom_range(31));
			endcase
		end else if (pick < 92) begin
			r.op = 1'($urandom_range(1));
			if ($urandom_range(1))
				r.kind = KIND_INVALID;
			else
				r.hash = '0;
		end else begin
			r.op = 1'($urandom_range(1));
			r.kind = 2'($urandom_range(3));
			r.height = rand64();
			r.round = $urandom;
			r.hash = {rand64(), rand64(), rand64(), rand64()};
		end
		return r;
	endfunction

	// Offer one request beat, idling at random first; note it on accept
	task automatic push(sign_req_t r);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= r.op;
		req.kind <= r.kind;
		req.height <= r.height;
		req.round <= r.round;
		req.hash_word0 <= r.hash[0];
		req.hash_word1 <= r.hash[1];
		req.hash_word2 <= r.hash[2];
		req.hash_word3 <= r.hash[3];
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_request(r);
		if (r.kind != KIND_INVALID && r.hash != '0)
			signed_log.push_back(r);
		sent++;
	endtask

	initial begin : stimulus
		int unsigned n;
		sb = new;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.operation <= OP_RECORD;
		req.kind <= '0;
		req.height <= '0;
		req.round <= '0;
		req.hash_word0 <= '0;
		req.hash_word1 <= '0;
		req.hash_word2 <= '0;
		req.hash_word3 <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: append, repeat, conflict, invalid, replay, near misses
		push(build(OP_RECORD, 2'd0, '0, '0, '0, '0, '0, 64'd1));
		push(build(OP_RECORD, 2'd0, '0, '0, '0, '0, '0, 64'd1));
		push(build(OP_RECORD, 2'd0, '0, '0, 64'd1, '0, '0, '0));
		push(build(OP_RECORD, 2'd1, '1, '1, '1, '1, '1, '1));
		push(build(OP_RECORD, 2'd2, '1, '1, '1, '1, '1, '1));
		push(build(OP_RECORD, KIND_INVALID, '1, '1, '1, '1, '1, '1));
		push(build(OP_RESTORE, KIND_INVALID, '0, '0, '0, '0, '0, 64'd1));
		push(build(OP_RECORD, 2'd1, '1, '1, '0, '0, '0, '0));
		push(build(OP_RESTORE, 2'd2, '0, '0, '0, '0, '0, '0));
		push(build(OP_RESTORE, 2'd0, '0, '0, '0, '0, '0, 64'd1));
		push(build(OP_RESTORE, 2'd0, '0, '0, 64'd1, '0, '0, '0));
		push(build(OP_RECORD, 2'd0, '0, '0, '0, '0, '0, 64'd1));
		push(build(OP_RESTORE, 2'd2, 64'h8000_0000_0000_0000, 32'h8000_0000,
			'0, 64'h8000_0000_0000_0000, '0, '0));
		push(build(OP_RECORD, 2'd1, '1, 32'hFFFF_FFFE, '1, '1, '1, '1));
		push(build(OP_RECORD, 2'd1, 64'hFFFF_FFFF_FFFF_FFFE, '1, '1, '1, '1, '1));
		push(build(OP_RECORD, 2'd0, '0, '0, '0, '0, 64'd1, 64'd1));
		push(build(OP_RESTORE, 2'd1, '1, '1, '1, '1, '1, '1));
		push(build(OP_RECORD, 2'd1, '1, '1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE));
		push(build(OP_RESTORE, 2'd2, '1, '1, '1, '1, '1, '1));

		// Random: one long rsp hold-off early, then a stretch with no idling
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 40)
				holdoff_req = 1'b1;
			quiet = (n >= 200 && n < 300);
			push(random_request());
		end
		quiet = 1'b0;
		req.valid <= 1'b0;

		// Drain outstanding results, then watch for strays
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests, checked %0d results in %0d cycles (%0d stalled input cycles).",
			sent, sb.checked, cycles, input_stalls);
		$display("Outcomes: %0d appended, %0d repeat, %0d conflict, %0d invalid, %0d full.",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
			sb.status_seen[3], sb.status_seen[4]);
		if (sb.errors == 0)
			$display("** signing_conflict_guard_table: PASSED **");
		else
			$display("** signing_conflict_guard_table: FAILED **");
		$finish;
	end

endmodule
